>>> src/pot_pkg.sv
// shared types and constants for the pad overlap test pipeline
// no dependencies; imported by every module of the block
package pot_pkg;

  localparam int COORD_BITS = 24;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        len_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    len_t   r;
  } circ_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } rect_t;

  // a plain pad uses rc only; a rounded pad uses both end circles too
  typedef struct packed {
    logic  rounded;
    circ_t c0;
    rect_t rc;
    circ_t c2;
  } pad_shapes_t;

  // per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pot_en_t;

endpackage

>>> src/pot_split.sv
// corner sort and shape split of one pad, two register stages
// depends on pot_pkg
module pot_split import pot_pkg::*; (
  input  logic        clk,
  input  coord_t      x1,
  input  coord_t      y1,
  input  coord_t      x2,
  input  coord_t      y2,
  input  logic        rounded,
  input  pot_en_t     en,
  output pad_shapes_t shapes
);

  // stage 1: sorted box
  coord_t minx, maxx, miny, maxy;
  len_t   w, h;
  logic   rnd;

  logic signed [COORD_BITS:0] dw, dh;
  coord_t minx_next, maxx_next, miny_next, maxy_next;

  always_comb begin
    minx_next = ($signed(x1) < $signed(x2)) ? x1 : x2;
    maxx_next = ($signed(x1) < $signed(x2)) ? x2 : x1;
    miny_next = ($signed(y1) < $signed(y2)) ? y1 : y2;
    maxy_next = ($signed(y1) < $signed(y2)) ? y2 : y1;
    dw = {maxx_next[COORD_BITS-1], maxx_next} - {minx_next[COORD_BITS-1], minx_next};
    dh = {maxy_next[COORD_BITS-1], maxy_next} - {miny_next[COORD_BITS-1], miny_next};
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      minx <= minx_next;
      maxx <= maxx_next;
      miny <= miny_next;
      maxy <= maxy_next;
      w    <= dw[COORD_BITS-1:0];
      h    <= dh[COORD_BITS-1:0];
      rnd  <= rounded;
    end
  end

  // stage 2: end circles and middle rectangle
  pad_shapes_t shapes_next;
  logic        tall;
  len_t        r;
  coord_t      rs;

  always_comb begin
    tall = h > w;
    r    = tall ? (w >> 1) : (h >> 1);
    rs   = coord_t'(r);
    shapes_next.rounded = rnd;
    shapes_next.c0.r = r;
    shapes_next.c2.r = r;
    if (!rnd) begin
      shapes_next.rc = '{x0: minx, y0: miny, x1: maxx, y1: maxy};
    end else if (tall) begin
      shapes_next.rc = '{x0: minx, y0: miny + rs, x1: maxx, y1: maxy - rs};
    end else begin
      shapes_next.rc = '{x0: minx + rs, y0: miny, x1: maxx - rs, y1: maxy};
    end
    if (tall) begin
      shapes_next.c0.cx = minx + rs;
      shapes_next.c0.cy = maxy - rs;
      shapes_next.c2.cx = minx + rs;
      shapes_next.c2.cy = miny + rs;
    end else begin
      shapes_next.c0.cx = minx + rs;
      shapes_next.c0.cy = miny + rs;
      shapes_next.c2.cx = maxx - rs;
      shapes_next.c2.cy = miny + rs;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      shapes <= shapes_next;
    end
  end

endmodule

>>> src/pot_cr.sv
// circle against rectangle grown by the radius, result registered in stage 3
// depends on pot_pkg
module pot_cr import pot_pkg::*; (
  input  logic    clk,
  input  circ_t   c,
  input  rect_t   b,
  input  pot_en_t en,
  output logic    hit
);

  logic signed [COORD_BITS+1:0] cx, cy, lx, hx, ly, hy, re;
  logic hit_next;

  always_comb begin
    re = $signed({2'b00, c.r});
    cx = $signed({{2{c.cx[COORD_BITS-1]}}, c.cx});
    cy = $signed({{2{c.cy[COORD_BITS-1]}}, c.cy});
    lx = $signed({{2{b.x0[COORD_BITS-1]}}, b.x0}) - re;
    hx = $signed({{2{b.x1[COORD_BITS-1]}}, b.x1}) + re;
    ly = $signed({{2{b.y0[COORD_BITS-1]}}, b.y0}) - re;
    hy = $signed({{2{b.y1[COORD_BITS-1]}}, b.y1}) + re;
    hit_next = !(cx < lx || cx > hx || cy < ly || cy > hy);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      hit <= hit_next;
    end
  end

endmodule

>>> src/pot_cc.sv
// circle against circle: distances in stage 3, squares in stage 4,
// compare left combinational for the stage 5 register in the top level
// depends on pot_pkg
module pot_cc import pot_pkg::*; (
  input  logic    clk,
  input  circ_t   p,
  input  circ_t   q,
  input  pot_en_t en,
  output logic    hit
);

  logic signed [COORD_BITS:0] ddx, ddy;
  len_t dx_next, dy_next, rs_next;
  len_t dx, dy, rs;
  logic [2*COORD_BITS-1:0] sqx, sqy, sqr;
  logic [2*COORD_BITS:0]   dist2;

  always_comb begin
    ddx = {p.cx[COORD_BITS-1], p.cx} - {q.cx[COORD_BITS-1], q.cx};
    ddy = {p.cy[COORD_BITS-1], p.cy} - {q.cy[COORD_BITS-1], q.cy};
    dx_next = ddx[COORD_BITS] ? len_t'(-ddx) : ddx[COORD_BITS-1:0];
    dy_next = ddy[COORD_BITS] ? len_t'(-ddy) : ddy[COORD_BITS-1:0];
    // each radius is below half the range, so the sum fits
    rs_next = p.r + q.r;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      dx <= dx_next;
      dy <= dy_next;
      rs <= rs_next;
    end
    if (en.s4) begin
      sqx <= dx * dx;
      sqy <= dy * dy;
      sqr <= rs * rs;
    end
  end

  always_comb begin
    dist2 = {1'b0, sqx} + {1'b0, sqy};
    hit   = dist2 <= {1'b0, sqr};
  end

endmodule

>>> src/pad_overlap_test_core.sv
// top level of the pad overlap test pipeline
// depends on pot_pkg, pot_split, pot_cr, pot_cc
//
// usage:
//   input channel: one beat carries pad A and pad B, each as two opposite
//   corners (signed) and a rounded flag; taken when in_valid and in_ready
//   are both high at a rising edge of clk.
//   output channel: one beat per input beat, overlaps = 1 when any shape of
//   pad A meets any shape of pad B; taken when out_valid and out_ready are
//   both high.
//   pipeline: the result passes five register stages before it is on the
//   output port (sort, split, compare/distance, square, final compare
//   into the output register).
//   throughput: one pad pair per cycle while the output is not stalled;
//   every stage is fixed logic; the widest is the 24 x 24 bit squaring in stage four.
//   reset: rst is synchronous, active high, and empties the pipeline; data
//   registers keep whatever they held.
//   stalls: when out_ready is low the output beat holds; each stage still
//   loads while it is empty, so bubbles close up and
//   in_ready stays high until all five stages hold beats.
module pad_overlap_test_core import pot_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t a_x1,
  input  coord_t a_y1,
  input  coord_t a_x2,
  input  coord_t a_y2,
  input  logic   a_rounded,
  input  coord_t b_x1,
  input  coord_t b_y1,
  input  coord_t b_x2,
  input  coord_t b_y2,
  input  logic   b_rounded,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   overlaps
);

  // pipeline control: a stage loads when it is empty or its successor loads
  logic    v1, v2, v3, v4;
  pot_en_t en;

  always_comb begin
    en.s5 = !out_valid || out_ready;
    en.s4 = !v4 || en.s5;
    en.s3 = !v3 || en.s4;
    en.s2 = !v2 || en.s3;
    en.s1 = !v1 || en.s2;
    in_ready = en.s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en.s1) v1 <= in_valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en.s4) v4 <= v3;
      if (en.s5) out_valid <= v4;
    end
  end

  // stages 1 and 2: sort corners and split each pad into its shapes
  pad_shapes_t sa, sb;

  pot_split u_split_a (
    .clk(clk), .x1(a_x1), .y1(a_y1), .x2(a_x2), .y2(a_y2),
    .rounded(a_rounded), .en(en), .shapes(sa)
  );

  pot_split u_split_b (
    .clk(clk), .x1(b_x1), .y1(b_y1), .x2(b_x2), .y2(b_y2),
    .rounded(b_rounded), .en(en), .shapes(sb)
  );

  // stage 3: end circles of one pad against the middle rectangle of the other
  logic cr_a0, cr_a2, cr_b0, cr_b2;

  pot_cr u_cr_a0 (.clk(clk), .c(sa.c0), .b(sb.rc), .en(en), .hit(cr_a0));
  pot_cr u_cr_a2 (.clk(clk), .c(sa.c2), .b(sb.rc), .en(en), .hit(cr_a2));
  pot_cr u_cr_b0 (.clk(clk), .c(sb.c0), .b(sa.rc), .en(en), .hit(cr_b0));
  pot_cr u_cr_b2 (.clk(clk), .c(sb.c2), .b(sa.rc), .en(en), .hit(cr_b2));

  // stages 3 to 5: every end circle pair, used only when both pads are rounded
  logic [3:0] cc_hit;

  pot_cc u_cc_00 (.clk(clk), .p(sa.c0), .q(sb.c0), .en(en), .hit(cc_hit[0]));
  pot_cc u_cc_02 (.clk(clk), .p(sa.c0), .q(sb.c2), .en(en), .hit(cc_hit[1]));
  pot_cc u_cc_20 (.clk(clk), .p(sa.c2), .q(sb.c0), .en(en), .hit(cc_hit[2]));
  pot_cc u_cc_22 (.clk(clk), .p(sa.c2), .q(sb.c2), .en(en), .hit(cc_hit[3]));

  // stage 3: rectangle against rectangle, touching edges count
  logic rr_next, rr3, a_rnd3, b_rnd3;

  always_comb begin
    rr_next = !($signed(sa.rc.x1) < $signed(sb.rc.x0) ||
                $signed(sb.rc.x1) < $signed(sa.rc.x0) ||
                $signed(sa.rc.y1) < $signed(sb.rc.y0) ||
                $signed(sb.rc.y1) < $signed(sa.rc.y0));
  end

  // stage 4: merge every test that does not need the squares
  logic other4, both4;

  // stage 5: final merge into the output register
  logic overlaps_next;

  always_comb begin
    overlaps_next = other4 || (both4 && (|cc_hit));
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      rr3    <= rr_next;
      a_rnd3 <= sa.rounded;
      b_rnd3 <= sb.rounded;
    end
    if (en.s4) begin
      other4 <= rr3 || (a_rnd3 && (cr_a0 || cr_a2)) || (b_rnd3 && (cr_b0 || cr_b2));
      both4  <= a_rnd3 && b_rnd3;
    end
    if (en.s5) begin
      overlaps <= overlaps_next;
    end
  end

endmodule
